// ----- hdl/fcr_pkg.sv -----
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared types, character constants and reply tables for the responder.
// ----------------------------------------------------------------------------
package fcr_pkg;

	localparam logic [7:0] START_MARK = 8'h3A;	// ':'
	localparam logic [7:0] END_MARK   = 8'h3B;	// ';'
	localparam int unsigned QUERY_LEN = 5;

	// reply index runs over ':' + body + ';'
	localparam int unsigned IDX_W     = 5;
	localparam logic [IDX_W-1:0] KNOWN_LAST = 5'd10;	// 9-byte body
	localparam logic [IDX_W-1:0] OTHER_LAST = 5'd16;	// 15-byte body

	typedef struct packed {
		logic rx_fire;	// input byte taken this cycle
		logic tx_start;	// frame end seen, set up reply
		logic tx_adv;	// current reply byte taken, step on
	} fcr_cmd_t;

	typedef struct packed {
		logic rx_is_end;	// incoming byte is ';'
		logic tx_last;	// presented byte is the closing ';'
	} fcr_status_t;

	// expected query text, one position at a time
	function automatic logic [7:0] query_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0:    c = 8'h2A;	// '*'
			3'd1:    c = 8'h49;	// 'I'
			3'd2:    c = 8'h44;	// 'D'
			3'd3:    c = 8'h4E;	// 'N'
			3'd4:    c = 8'h3F;	// '?'
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// reply bytes, including the framing marks
	function automatic logic [7:0] reply_char(input logic known, input logic [IDX_W-1:0] idx);
		logic [7:0] c;
		if (known) begin
			unique case (idx)
				5'd0:    c = START_MARK;
				5'd1:    c = 8'h57;	// W
				5'd2:    c = 8'h65;	// e
				5'd3:    c = 8'h27;	// '
				5'd4:    c = 8'h72;	// r
				5'd5:    c = 8'h65;	// e
				5'd6:    c = 8'h20;	// space
				5'd7:    c = 8'h45;
				5'd8:    c = 8'h69;
				5'd9:    c = 8'h54;
				5'd10:   c = END_MARK;
				default: c = 8'h00;
			endcase
		end else begin
			unique case (idx)
				5'd0:    c = START_MARK;
				5'd1:    c = 8'h55;	// U
				5'd2:    c = 8'h6E;	// n
				5'd3:    c = 8'h6B;	// k
				5'd4:    c = 8'h6E;	// n
				5'd5:    c = 8'h6F;	// o
				5'd6:    c = 8'h77;	// w
				5'd7:    c = 8'h6E;	// n
				5'd8:    c = 8'h20;	// space
				5'd9:    c = 8'h63;	// c
				5'd10:   c = 8'h6F;	// o
				5'd11:   c = 8'h6D;	// m
				5'd12:   c = 8'h6D;	// m
				5'd13:   c = 8'h61;	// a
				5'd14:   c = 8'h6E;	// n
				5'd15:   c = 8'h64;	// d
				5'd16:   c = END_MARK;
				default: c = 8'h00;
			endcase
		end
		return c;
	endfunction

endpackage

// ----- hdl/fcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// fcr_ctrl
// Receive / transmit sequencer: owns both handshakes, drives the datapath.
// ----------------------------------------------------------------------------
module fcr_ctrl import fcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  fcr_status_t status,
	output fcr_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_RX = 2'b01,
		ST_TX = 2'b10
	} fcr_state_t;

	fcr_state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		cmd.rx_fire  = 1'b0;
		cmd.tx_start = 1'b0;
		cmd.tx_adv   = 1'b0;
		unique case (state_q)
			ST_RX: begin
				in_ready    = 1'b1;
				cmd.rx_fire = in_valid;
				if (in_valid && status.rx_is_end) begin
					cmd.tx_start = 1'b1;
					state_d      = ST_TX;
				end
			end
			ST_TX: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (status.tx_last) begin
						state_d = ST_RX;
					end else begin
						cmd.tx_adv = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_RX;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RX;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/fcr_datapath.sv -----
// ----------------------------------------------------------------------------
// fcr_datapath
// Frame count, query match flag and reply byte pointer.
// ----------------------------------------------------------------------------
module fcr_datapath import fcr_pkg::*; #(
	parameter int unsigned CNT_W = 5,
	parameter int unsigned DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  fcr_cmd_t    cmd,
	input  logic [7:0]  rx_byte,
	output fcr_status_t status,
	output logic [7:0]  tx_byte,
	output logic        tx_last
);

	logic [CNT_W-1:0] count_q;
	logic             match_q;
	logic             known_q;
	logic [IDX_W-1:0] idx_q;
	logic             is_start;
	logic             is_end;
	logic             frame_ok;

	assign is_start = (rx_byte == START_MARK);
	assign is_end   = (rx_byte == END_MARK);
	assign frame_ok = (count_q == CNT_W'(QUERY_LEN)) && match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			match_q <= 1'b1;
		end else if (cmd.rx_fire && !is_end) begin
			if (is_start) begin
				count_q <= '0;
				match_q <= 1'b1;
			end else if (count_q < CNT_W'(DEPTH - 1)) begin
				// only the first five positions take part in the match
				if (count_q < CNT_W'(QUERY_LEN) && rx_byte != query_char(count_q[2:0])) begin
					match_q <= 1'b0;
				end
				count_q <= count_q + CNT_W'(1);
			end else begin
				// overflow: byte dropped, count wraps
				count_q <= '0;
				match_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q <= 1'b0;
			idx_q   <= '0;
		end else if (cmd.tx_start) begin
			known_q <= frame_ok;
			idx_q   <= '0;
		end else if (cmd.tx_adv) begin
			idx_q   <= idx_q + IDX_W'(1);
		end
	end

	assign tx_byte        = reply_char(known_q, idx_q);
	assign tx_last        = (idx_q == (known_q ? KNOWN_LAST : OTHER_LAST));
	assign status.rx_is_end = is_end;
	assign status.tx_last   = tx_last;

endmodule

// ----- hdl/framed_command_responder_top.sv -----
// ----------------------------------------------------------------------------
// framed_command_responder_top
// Framed ASCII identity query responder: ':' opens a frame, ';' closes it and
// triggers a framed reply, known or unknown command.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata             tlast           per item
//  s_axis    in   [7:0] rx_byte     -               one received byte
//  m_axis    out  [7:0] tx_byte     last_of_reply   one reply byte
//
//  Cycles : one received byte per cycle while no reply is pending. A ';'
//           starts a reply of 11 (match) or 17 (no match) bytes, one per
//           cycle at best; input is held off until the closing byte is taken.
//  Reset  : arst_n clears the frame count to zero, the match flag to one and
//           returns the sequencer to receive.
//  Stalls : m_axis_tready low freezes the reply pointer, so the presented
//           byte holds until taken.
//
module framed_command_responder_top import fcr_pkg::*; #(
	parameter int unsigned FRAME_BUFFER_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	// received stream
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,	// [7:0] rx_byte
	// reply stream
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,	// [7:0] tx_byte
	output logic       m_axis_tlast	// last_of_reply
);

	// count reaches depth-1 at most
	localparam int unsigned CNT_W = $clog2(FRAME_BUFFER_DEPTH);

	fcr_cmd_t    cmd;
	fcr_status_t status;

	fcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	fcr_datapath #(
		.CNT_W (CNT_W),
		.DEPTH (FRAME_BUFFER_DEPTH)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rx_byte (s_axis_tdata),
		.status  (status),
		.tx_byte (m_axis_tdata),
		.tx_last (m_axis_tlast)
	);

endmodule
